>>> hdl/gld_pkg.sv
// Package for the GIF LZW decoder: payload structs, sequencer states and
// the status, action and size constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gld_pkg;

	localparam int TABLE_ENTRIES = 4096;
	localparam int MAX_CODE_BITS = 12;
	localparam int STACK_ENTRIES = TABLE_ENTRIES + 1;

	localparam logic [1:0] ACT_PUSH    = 2'd0;
	localparam logic [1:0] ACT_PULL    = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;
	localparam logic [1:0] ACT_UNUSED  = 2'd3;

	localparam logic [2:0] STS_ACCEPT = 3'd0;
	localparam logic [2:0] STS_REFUSE = 3'd1;
	localparam logic [2:0] STS_PIXEL  = 3'd2;
	localparam logic [2:0] STS_NEED   = 3'd3;
	localparam logic [2:0] STS_ENDED  = 3'd4;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] pixel_index;
	} out_item_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_DECODE,
		SQ_CHAIN_RD,
		SQ_CHAIN_WR,
		SQ_POP_RD,
		SQ_POP_OUT
	} seq_state_t;

endpackage
`default_nettype wire

>>> hdl/gif_lzw_decoder.sv
// GIF LZW image data decoder: bit buffer, code tables, pixel stack and sequencer.
// Depends on gld_pkg.
`timescale 1ns / 1ps
`default_nettype none
// The decoder takes one transfer at a time on the input channel, each being an
// action: push one raw stream byte (sub-block length bytes included), pull the
// next pixel index, or restart the decoding state. Every action answers with
// exactly one result transfer holding a status and, for status 2, the pixel.
// A push, a restart or an unused action is answered straight from idle. A pull
// that finds pixels waiting on the stack reads the stack memory, which has a
// registered read, and then returns the pixel. A pull that must decode unpacks
// codes one at a time (clear codes included) until bits run short, the end code
// comes or a data code is found; the first code after a clear is returned as
// the pixel, any other is traced along the prefix chain, each link being one
// read of the suffix/prefix table followed by one push onto the pixel stack,
// and then the string is closed and its first pixel popped. The input is not
// ready while an action is in progress or while a result waits to be taken, so
// a new action is not taken before the last result has been taken.
// The user must write the min_code_size register through cfg_wdata/cfg_we only
// while idle; the block itself does not enforce this. Its code width and table
// start take effect at the next clear code or restart, but the clear and end
// codes follow the new value at once. The tables and the stack are not cleared
// by reset or restart; the stream itself defines every entry it reads.
module gif_lzw_decoder (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  gld_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  wire                out_ready,
	output gld_pkg::out_item_t out_data,
	input  wire                cfg_we,
	input  wire  [3:0]         cfg_wdata
);
	import gld_pkg::*;

	// Architectural state.
	logic [3:0]  min_size_q;
	logic [31:0] bit_buf_q, bit_buf_d;
	logic [5:0]  bits_held_q, bits_held_d;
	logic [7:0]  blk_left_q, blk_left_d;
	logic [3:0]  code_width_q, code_width_d;
	logic [12:0] next_slot_q, next_slot_d;
	logic [12:0] slot_limit_q, slot_limit_d;
	logic [11:0] old_code_q, old_code_d;
	logic [7:0]  first_char_q, first_char_d;
	logic [12:0] depth_q, depth_d;
	logic        ended_q, ended_d;
	logic        await_q, await_d;

	// Sequencer working registers.
	seq_state_t  state_q, state_d;
	logic [11:0] code_q, code_d;
	logic [11:0] cur_c_q, cur_c_d;
	logic [12:0] links_q, links_d;
	logic        out_valid_q, out_valid_d;
	out_item_t   out_data_q, out_data_d;

	// Memories.
	logic [7:0]  suffix_mem [TABLE_ENTRIES];
	logic [11:0] prefix_mem [TABLE_ENTRIES];
	logic [7:0]  stack_mem  [STACK_ENTRIES];
	logic [7:0]  suffix_rd_q;
	logic [11:0] prefix_rd_q;
	logic [7:0]  stack_rd_q;

	logic        tbl_we;
	logic [11:0] tbl_waddr;
	logic [7:0]  tbl_wsuffix;
	logic [11:0] tbl_wprefix;
	logic        stk_we;
	logic [12:0] stk_waddr;
	logic [7:0]  stk_wdata;
	logic        stk_re;

	// Table start values derived from the clamped minimum code size.
	logic [3:0]  eff_m;
	logic [9:0]  clr_code;
	logic [11:0] clr12;
	logic [12:0] start_next;
	logic [12:0] start_limit;
	logic [3:0]  start_width;

	// Code extraction by masking the low bits of the bit buffer.
	logic [31:0] width_mask;
	logic [31:0] code_bits;
	logic [11:0] c_raw;
	logic        in_xfer;

	assign in_ready  = (state_q == SQ_IDLE) && !out_valid_q;
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		eff_m = min_size_q;
		if (eff_m < 4'd2) begin
			eff_m = 4'd2;
		end
		if (eff_m > 4'd9) begin
			eff_m = 4'd9;
		end
		clr_code    = 10'd1 << eff_m;
		clr12       = {2'b00, clr_code};
		start_width = eff_m + 4'd1;
		start_next  = {3'b000, clr_code} + 13'd2;
		start_limit = 13'd1 << start_width;
		width_mask  = (32'd1 << code_width_q) - 32'd1;
		code_bits   = bit_buf_q & width_mask;
		c_raw       = code_bits[11:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_size_q <= 4'd8;
		end else if (cfg_we) begin
			min_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= SQ_IDLE;
			bit_buf_q    <= '0;
			bits_held_q  <= '0;
			blk_left_q   <= '0;
			code_width_q <= 4'd9;
			next_slot_q  <= 13'd258;
			slot_limit_q <= 13'd512;
			old_code_q   <= '0;
			first_char_q <= '0;
			depth_q      <= '0;
			ended_q      <= 1'b0;
			await_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			bit_buf_q    <= bit_buf_d;
			bits_held_q  <= bits_held_d;
			blk_left_q   <= blk_left_d;
			code_width_q <= code_width_d;
			next_slot_q  <= next_slot_d;
			slot_limit_q <= slot_limit_d;
			old_code_q   <= old_code_d;
			first_char_q <= first_char_d;
			depth_q      <= depth_d;
			ended_q      <= ended_d;
			await_q      <= await_d;
			out_valid_q  <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		code_q     <= code_d;
		cur_c_q    <= cur_c_d;
		links_q    <= links_d;
		out_data_q <= out_data_d;
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			suffix_mem[tbl_waddr] <= tbl_wsuffix;
			prefix_mem[tbl_waddr] <= tbl_wprefix;
		end
		suffix_rd_q <= suffix_mem[code_q];
		prefix_rd_q <= prefix_mem[code_q];
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[stk_waddr] <= stk_wdata;
		end
		if (stk_re) begin
			stack_rd_q <= stack_mem[depth_d];
		end
	end

	always_comb begin
		logic        upd;
		logic [12:0] ns;
		logic [11:0] c_use;
		state_d      = state_q;
		bit_buf_d    = bit_buf_q;
		bits_held_d  = bits_held_q;
		blk_left_d   = blk_left_q;
		code_width_d = code_width_q;
		next_slot_d  = next_slot_q;
		slot_limit_d = slot_limit_q;
		old_code_d   = old_code_q;
		first_char_d = first_char_q;
		depth_d      = depth_q;
		ended_d      = ended_q;
		await_d      = await_q;
		code_d       = code_q;
		cur_c_d      = cur_c_q;
		links_d      = links_q;
		out_valid_d  = out_valid_q;
		out_data_d   = out_data_q;
		tbl_we       = 1'b0;
		tbl_waddr    = next_slot_q[11:0];
		tbl_wsuffix  = code_q[7:0];
		tbl_wprefix  = old_code_q;
		stk_we       = 1'b0;
		stk_waddr    = depth_q;
		stk_wdata    = first_char_q;
		stk_re       = 1'b0;
		upd          = 1'b0;
		ns           = next_slot_q;
		c_use        = c_raw;

		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			SQ_IDLE: begin
				if (in_xfer) begin
					out_data_d.pixel_index = '0;
					case (in_data.action)
						ACT_PUSH: begin
							out_valid_d       = 1'b1;
							out_data_d.status = STS_ACCEPT;
							if (ended_q) begin
								out_data_d.status = STS_REFUSE;
							end else if (blk_left_q == 8'd0) begin
								if (in_data.data_byte == 8'd0) begin
									ended_d = 1'b1;
								end else begin
									blk_left_d = in_data.data_byte;
								end
							end else if (bits_held_q > 6'd24) begin
								out_data_d.status = STS_REFUSE;
							end else begin
								bit_buf_d   = bit_buf_q |
									({24'd0, in_data.data_byte} << bits_held_q);
								bits_held_d = bits_held_q + 6'd8;
								blk_left_d  = blk_left_q - 8'd1;
							end
						end
						ACT_PULL: begin
							if (depth_q != 13'd0) begin
								state_d = SQ_POP_RD;
							end else begin
								state_d = SQ_DECODE;
							end
						end
						ACT_RESTART: begin
							out_valid_d       = 1'b1;
							out_data_d.status = STS_ACCEPT;
							bit_buf_d         = '0;
							bits_held_d       = '0;
							blk_left_d        = '0;
							old_code_d        = '0;
							first_char_d      = '0;
							depth_d           = '0;
							ended_d           = 1'b0;
							await_d           = 1'b0;
							code_width_d      = start_width;
							next_slot_d       = start_next;
							slot_limit_d      = start_limit;
						end
						default: begin
							out_valid_d       = 1'b1;
							out_data_d.status = STS_REFUSE;
						end
					endcase
				end
			end
			SQ_DECODE: begin
				// One code per cycle; clear codes loop back here.
				if (bits_held_q < {2'b00, code_width_q}) begin
					out_valid_d            = 1'b1;
					out_data_d.pixel_index = '0;
					out_data_d.status      = ended_q ? STS_ENDED : STS_NEED;
					state_d                = SQ_IDLE;
				end else begin
					bit_buf_d   = bit_buf_q >> code_width_q;
					bits_held_d = bits_held_q - {2'b00, code_width_q};
					if (c_raw == clr12 + 12'd1) begin
						ended_d                = 1'b1;
						await_d                = 1'b0;
						bit_buf_d              = '0;
						bits_held_d            = '0;
						out_valid_d            = 1'b1;
						out_data_d.pixel_index = '0;
						out_data_d.status      = STS_ENDED;
						state_d                = SQ_IDLE;
					end else if (c_raw == clr12) begin
						code_width_d = start_width;
						next_slot_d  = start_next;
						slot_limit_d = start_limit;
						await_d      = 1'b1;
					end else if (await_q) begin
						if ({1'b0, c_raw} >= next_slot_q) begin
							c_use = '0;
						end
						old_code_d             = c_use;
						first_char_d           = c_use[7:0];
						await_d                = 1'b0;
						out_valid_d            = 1'b1;
						out_data_d.status      = STS_PIXEL;
						out_data_d.pixel_index = c_use[7:0];
						state_d                = SQ_IDLE;
					end else begin
						cur_c_d = c_raw;
						code_d  = c_raw;
						links_d = '0;
						if ({1'b0, c_raw} >= next_slot_q) begin
							// Code not yet in the table: previous string plus its first pixel.
							code_d = old_code_q;
							if (depth_q < 13'(STACK_ENTRIES)) begin
								stk_we    = 1'b1;
								stk_wdata = first_char_q;
								depth_d   = depth_q + 13'd1;
							end
						end
						state_d = SQ_CHAIN_RD;
					end
				end
			end
			SQ_CHAIN_RD: begin
				if ((code_q >= clr12 + 12'd2) && (links_q < 13'(TABLE_ENTRIES))) begin
					state_d = SQ_CHAIN_WR;
				end else begin
					// Root of the chain (or link limit reached): push it and, if a slot is free, add the new table entry.
					if (depth_q < 13'(STACK_ENTRIES)) begin
						stk_we    = 1'b1;
						stk_wdata = code_q[7:0];
						depth_d   = depth_q + 13'd1;
					end
					upd = next_slot_q < slot_limit_q;
					if (upd) begin
						first_char_d = code_q[7:0];
						tbl_we       = next_slot_q < 13'(TABLE_ENTRIES);
						next_slot_d  = next_slot_q + 13'd1;
						old_code_d   = cur_c_q;
					end
					ns = next_slot_q + {12'd0, upd};
					if ((ns >= slot_limit_q) && (code_width_q < 4'(MAX_CODE_BITS))) begin
						slot_limit_d = slot_limit_q << 1;
						code_width_d = code_width_q + 4'd1;
					end
					state_d = SQ_POP_RD;
				end
			end
			SQ_CHAIN_WR: begin
				if (depth_q < 13'(STACK_ENTRIES)) begin
					stk_we    = 1'b1;
					stk_wdata = suffix_rd_q;
					depth_d   = depth_q + 13'd1;
				end
				code_d  = prefix_rd_q;
				links_d = links_q + 13'd1;
				state_d = SQ_CHAIN_RD;
			end
			SQ_POP_RD: begin
				depth_d = depth_q - 13'd1;
				stk_re  = 1'b1;
				state_d = SQ_POP_OUT;
			end
			SQ_POP_OUT: begin
				out_valid_d            = 1'b1;
				out_data_d.status      = STS_PIXEL;
				out_data_d.pixel_index = stack_rd_q;
				state_d                = SQ_IDLE;
			end
			default: begin
				state_d = SQ_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire
